@@ hdl/pdm_pkg.sv @@
// Shared constants, widths and quaternion helpers for the posture delay and mirror block.
package pdm_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 512;
  localparam int SLOT_W     = $clog2(RING_DEPTH);

  // Field widths.
  localparam int TIME_W      = 32;
  localparam int QUAT_W      = 64;
  localparam int COMP_W      = 16;
  localparam int DELAY_W     = 24;
  localparam int MODE_W      = 2;
  localparam int USED_SLOT_W = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;
  localparam int POSE_W      = 4 * QUAT_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_US    = 1'b1;

  // Mirror modes.
  localparam logic [MODE_W-1:0] MODE_LEFT_DRIVES_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT_DRIVES_LEFT = 2'd2;

  // Register reset values.
  localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_LEFT_DRIVES_RIGHT;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd1000000;

  // Identity quaternion: w = 1.0 in Q2.14, x = y = z = 0.
  localparam logic [QUAT_W-1:0] IDENTITY_QUAT = 64'h4000_0000_0000_0000;

  // Two's complement negation that saturates the most negative value.
  function automatic logic [COMP_W-1:0] neg_sat(input logic [COMP_W-1:0] c);
    logic [COMP_W-1:0] r;
    if (c == 16'h8000) begin
      r = 16'h7fff;
    end else begin
      r = ~c + 16'd1;
    end
    return r;
  endfunction

  // Reflects a joint orientation across the body plane: y and z change sign.
  function automatic logic [QUAT_W-1:0] mirror_quat(input logic [QUAT_W-1:0] q);
    return {q[63:32], neg_sat(q[31:16]), neg_sat(q[15:0])};
  endfunction

endpackage

@@ hdl/pdm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/posture_delay_and_mirror_core.sv @@
// Top level of the posture delay and mirror block: ring store, nearest-time scan and mirror.
// With the delayed lookup, an accepted request passes through 512 reads of the time store,
// a three-stage compare pipeline and one quaternion read before its result is valid;
// without it, only the quaternion read. A new request is accepted in the cycle after the
// result register is loaded, so the block does not take a new request while one is in work.
// Reset (rst_ni, asynchronous, active low) clears the control state and loads the register
// defaults; ring entries not yet written since reset read as time zero and identity poses.
module posture_delay_and_mirror_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pdm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input posture requests.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pdm_pkg::TIME_W-1:0]          timestamp_us_i,
  input  logic [pdm_pkg::QUAT_W-1:0]          left_elbow_quat_i,
  input  logic [pdm_pkg::QUAT_W-1:0]          left_wrist_quat_i,
  input  logic [pdm_pkg::QUAT_W-1:0]          right_elbow_quat_i,
  input  logic [pdm_pkg::QUAT_W-1:0]          right_wrist_quat_i,
  // Output posture results.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pdm_pkg::QUAT_W-1:0]          out_left_elbow_quat_o,
  output logic [pdm_pkg::QUAT_W-1:0]          out_left_wrist_quat_o,
  output logic [pdm_pkg::QUAT_W-1:0]          out_right_elbow_quat_o,
  output logic [pdm_pkg::QUAT_W-1:0]          out_right_wrist_quat_o,
  output logic [pdm_pkg::USED_SLOT_W-1:0]     used_slot_o
);

  import pdm_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_SCAN = 2'd1;  // sweeping the time store
  localparam logic [1:0] S_READ = 2'd2;  // reading the selected pose
  localparam logic [1:0] S_OUT  = 2'd3;  // loading the result register

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [MODE_W-1:0]  mode_q;
  logic [DELAY_W-1:0] delay_q;

  // Ring bookkeeping. An entry holds written data when the ring has wrapped once or when
  // its index lies below the write pointer; otherwise it still holds its reset value.
  logic [SLOT_W-1:0] wr_slot_q;
  logic              wrapped_q;

  // Current request, held for the pass-through arm.
  logic [QUAT_W-1:0] le_q, lw_q, re_q, rw_q;

  // Scan control and the compare pipeline.
  logic [TIME_W-1:0] target_q;
  logic [SLOT_W-1:0] scan_idx_q;
  logic              issue_done_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              d_vld_q;
  logic [SLOT_W-1:0] d_idx_q;
  logic [TIME_W-1:0] d_q;
  logic              have_q;
  logic [TIME_W-1:0] best_q;
  logic [SLOT_W-1:0] sel_q;

  // Result register.
  logic              out_valid_q;
  logic [QUAT_W-1:0] out_le_q, out_lw_q, out_re_q, out_rw_q;
  logic [SLOT_W-1:0] out_slot_q;

  logic              accept;
  logic              lookup;
  logic [SLOT_W-1:0] ram_raddr;
  logic [TIME_W-1:0] time_rdata;
  logic [POSE_W-1:0] pose_rdata;
  logic [TIME_W-1:0] stored_t;
  logic [TIME_W-1:0] time_gap;
  logic              pose_written;
  logic [QUAT_W-1:0] st_le, st_lw, st_re, st_rw;
  logic              load_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // The delayed lookup runs only for a nonzero delay that the timestamp has already reached.
  assign lookup = (delay_q != '0) && (timestamp_us_i >= TIME_W'(delay_q));

  // The time store is read by the scan, the pose store at the selected slot.
  assign ram_raddr = (state_q == S_SCAN) ? scan_idx_q : sel_q;

  pdm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (RING_DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_slot_q),
    .wdata_i (timestamp_us_i),
    .raddr_i (ram_raddr),
    .rdata_o (time_rdata)
  );

  pdm_ram #(
    .WIDTH (POSE_W),
    .DEPTH (RING_DEPTH)
  ) u_pose_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_slot_q),
    .wdata_i ({left_elbow_quat_i, left_wrist_quat_i, right_elbow_quat_i, right_wrist_quat_i}),
    .raddr_i (ram_raddr),
    .rdata_o (pose_rdata)
  );

  // A slot not yet written since reset holds time zero.
  assign stored_t = (wrapped_q || (rd_idx_q < wr_slot_q)) ? time_rdata : '0;

  // Exact distance between the stored time and the target.
  assign time_gap = (stored_t > target_q) ? (stored_t - target_q) : (target_q - stored_t);

  // Selected pose, with the identity standing in for a slot never written.
  assign pose_written = wrapped_q || (sel_q < wr_slot_q);
  assign st_le = pose_written ? pose_rdata[4*QUAT_W-1:3*QUAT_W] : IDENTITY_QUAT;
  assign st_lw = pose_written ? pose_rdata[3*QUAT_W-1:2*QUAT_W] : IDENTITY_QUAT;
  assign st_re = pose_written ? pose_rdata[2*QUAT_W-1:QUAT_W]   : IDENTITY_QUAT;
  assign st_rw = pose_written ? pose_rdata[QUAT_W-1:0]          : IDENTITY_QUAT;

  // The result register takes a new result once the previous one has been taken.
  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = lookup ? S_SCAN : S_READ;
        end
      end
      S_SCAN: begin
        // Leave once every read is issued and the compare pipeline has drained.
        if (issue_done_q && !rd_vld_q && !d_vld_q) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_RESET;
      delay_q      <= DELAY_RESET;
      wr_slot_q    <= '0;
      wrapped_q    <= 1'b0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      d_vld_q      <= 1'b0;
      have_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIRROR_MODE: mode_q  <= cfg_data_i[MODE_W-1:0];
          CFG_DELAY_US:    delay_q <= cfg_data_i[DELAY_W-1:0];
          default:         mode_q  <= mode_q;
        endcase
      end

      if (accept) begin
        if (wr_slot_q == LAST_SLOT) begin
          wr_slot_q <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wr_slot_q <= wr_slot_q + 1'b1;
        end
      end

      // Read issue runs from the highest slot down to slot zero.
      if (accept) begin
        issue_done_q <= 1'b0;
      end else if ((state_q == S_SCAN) && !issue_done_q && (scan_idx_q == '0)) begin
        issue_done_q <= 1'b1;
      end

      rd_vld_q <= (state_q == S_SCAN) && !issue_done_q;
      d_vld_q  <= rd_vld_q;

      // Strict less-than while scanning downward lets the highest slot win a tie.
      if (accept) begin
        have_q <= 1'b0;
      end else if (d_vld_q && (!have_q || (d_q < best_q))) begin
        have_q <= 1'b1;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      le_q       <= left_elbow_quat_i;
      lw_q       <= left_wrist_quat_i;
      re_q       <= right_elbow_quat_i;
      rw_q       <= right_wrist_quat_i;
      target_q   <= timestamp_us_i - TIME_W'(delay_q);
      scan_idx_q <= LAST_SLOT;
      // Without the lookup the slot just written supplies the mirrored arm.
      sel_q      <= wr_slot_q;
    end else begin
      if ((state_q == S_SCAN) && !issue_done_q) begin
        scan_idx_q <= scan_idx_q - 1'b1;
      end
      if (d_vld_q && (!have_q || (d_q < best_q))) begin
        best_q <= d_q;
        sel_q  <= d_idx_q;
      end
    end

    rd_idx_q <= scan_idx_q;
    d_idx_q  <= rd_idx_q;
    d_q      <= time_gap;

    if (load_out) begin
      out_le_q   <= le_q;
      out_lw_q   <= lw_q;
      out_re_q   <= re_q;
      out_rw_q   <= rw_q;
      out_slot_q <= sel_q;
      case (mode_q)
        MODE_LEFT_DRIVES_RIGHT: begin
          out_re_q <= mirror_quat(st_le);
          out_rw_q <= mirror_quat(st_lw);
        end
        MODE_RIGHT_DRIVES_LEFT: begin
          out_le_q <= mirror_quat(st_re);
          out_lw_q <= mirror_quat(st_rw);
        end
        default: begin
          out_slot_q <= sel_q;
        end
      endcase
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_left_elbow_quat_o  = out_le_q;
  assign out_left_wrist_quat_o  = out_lw_q;
  assign out_right_elbow_quat_o = out_re_q;
  assign out_right_wrist_quat_o = out_rw_q;
  assign used_slot_o            = USED_SLOT_W'(out_slot_q);

`ifndef NO_ASSERTIONS
  // The block takes one request at a time: no request right after one is accepted.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted while the previous one is still in work");

  // The pose read only starts once the compare pipeline is empty.
  a_scan_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (!rd_vld_q && !d_vld_q))
    else $error("pose read started with compares still in flight");

  // A request without lookup reports the slot it was written to.
  a_direct_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !lookup) |=> (sel_q == $past(wr_slot_q) && state_q == S_READ))
    else $error("direct request did not select the slot just written");

  // A result that waits for the receiver stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_le_q) &&
      $stable(out_lw_q) && $stable(out_re_q) && $stable(out_rw_q) && $stable(out_slot_q)))
    else $error("waiting result changed before it was taken");
`endif

endmodule
